// ----- design/rhba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the RGB horizontal box average block.
// No dependencies.
package rhba_pkg;

	localparam int MAX_GROUP = 4096;
	localparam int CFG_W     = 13;
	localparam int PIX_W     = 8;
	localparam int LEN_W     = $clog2(MAX_GROUP + 1);
	localparam int CNT_W     = $clog2(MAX_GROUP);
	localparam int SUM_W     = $clog2(MAX_GROUP * 255 + 1);
	localparam int DV_W      = LEN_W + PIX_W;
	localparam int STEP_W    = $clog2(PIX_W);
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		sum_t sum_red;
		sum_t sum_green;
		sum_t sum_blue;
		len_t len;
	} grp_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_HOLD
	} back_state_t;

	function automatic len_t eff_len(input cfg_t v);
		len_t r;
		if (v == '0) begin
			r = len_t'(1);
		end else if (int'(v) > MAX_GROUP) begin
			r = len_t'(MAX_GROUP);
		end else begin
			r = len_t'(v);
		end
		return r;
	endfunction

endpackage

// ----- design/rhba_front.sv -----
`timescale 1ns / 1ps
// Front end: group length register, pixel accumulation and group completion.
// Depends on rhba_pkg.
module rhba_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  rhba_pkg::cfg_t  cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  rhba_pkg::pix_t  red,
	input  rhba_pkg::pix_t  green,
	input  rhba_pkg::pix_t  blue,
	input  logic            q_full,
	output logic            q_push,
	output rhba_pkg::grp_t  q_data
);

	rhba_pkg::cfg_t              group_length_q;
	rhba_pkg::sum_t              sum_red_q;
	rhba_pkg::sum_t              sum_green_q;
	rhba_pkg::sum_t              sum_blue_q;
	logic [rhba_pkg::CNT_W-1:0]  cnt_q;
	rhba_pkg::len_t              len;
	rhba_pkg::len_t              cnt_next;
	rhba_pkg::sum_t              sr_next;
	rhba_pkg::sum_t              sg_next;
	rhba_pkg::sum_t              sb_next;
	logic                        done;
	logic                        fire;

	always_comb begin
		len      = rhba_pkg::eff_len(group_length_q);
		cnt_next = rhba_pkg::LEN_W'(cnt_q) + rhba_pkg::LEN_W'(1);
		done     = (cnt_next >= len);
		sr_next  = sum_red_q + rhba_pkg::SUM_W'(red);
		sg_next  = sum_green_q + rhba_pkg::SUM_W'(green);
		sb_next  = sum_blue_q + rhba_pkg::SUM_W'(blue);
		in_ready = !q_full || !done;
		fire     = in_valid && in_ready;
		q_push   = fire && done;
		q_data.sum_red   = sr_next;
		q_data.sum_green = sg_next;
		q_data.sum_blue  = sb_next;
		q_data.len       = len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_length_q <= rhba_pkg::cfg_t'(1);
		end else if (cfg_we) begin
			group_length_q <= cfg_data;
		end
	end

	// accumulate; clear on group completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_red_q   <= '0;
			sum_green_q <= '0;
			sum_blue_q  <= '0;
			cnt_q       <= '0;
		end else if (fire) begin
			if (done) begin
				sum_red_q   <= '0;
				sum_green_q <= '0;
				sum_blue_q  <= '0;
				cnt_q       <= '0;
			end else begin
				sum_red_q   <= sr_next;
				sum_green_q <= sg_next;
				sum_blue_q  <= sb_next;
				cnt_q       <= cnt_next[rhba_pkg::CNT_W-1:0];
			end
		end
	end

endmodule

// ----- design/rhba_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of completed groups between front end and divider.
// Depends on rhba_pkg.
module rhba_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rhba_pkg::grp_t  push_data,
	input  logic            pop,
	output rhba_pkg::grp_t  head,
	output logic            full,
	output logic            empty
);

	rhba_pkg::grp_t               mem [rhba_pkg::QDEPTH];
	logic [rhba_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [rhba_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [rhba_pkg::QCNT_W-1:0]  cnt_q;
	logic                         do_push;
	logic                         do_pop;

	always_comb begin
		full    = (cnt_q == rhba_pkg::QCNT_W'(rhba_pkg::QDEPTH));
		empty   = (cnt_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		head    = mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == rhba_pkg::QPTR_W'(rhba_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + rhba_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == rhba_pkg::QPTR_W'(rhba_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + rhba_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + rhba_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - rhba_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- design/rhba_divider.sv -----
`timescale 1ns / 1ps
// Back end: bit-serial division of the three channel sums by the group length,
// saturation to the pixel range, and the output register. Depends on rhba_pkg.
module rhba_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  rhba_pkg::grp_t  head,
	input  logic            q_empty,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output rhba_pkg::pix_t  avg_red,
	output rhba_pkg::pix_t  avg_green,
	output rhba_pkg::pix_t  avg_blue
);

	rhba_pkg::back_state_t         state_q;
	rhba_pkg::back_state_t         state_d;
	logic [rhba_pkg::DV_W-1:0]     rem_r_q;
	logic [rhba_pkg::DV_W-1:0]     rem_g_q;
	logic [rhba_pkg::DV_W-1:0]     rem_b_q;
	logic [rhba_pkg::DV_W-1:0]     dv_q;
	rhba_pkg::pix_t                quo_r_q;
	rhba_pkg::pix_t                quo_g_q;
	rhba_pkg::pix_t                quo_b_q;
	logic [2:0]                    sat_q;
	logic [rhba_pkg::STEP_W-1:0]   step_q;
	logic                          out_valid_q;
	rhba_pkg::pix_t                avg_r_q;
	rhba_pkg::pix_t                avg_g_q;
	rhba_pkg::pix_t                avg_b_q;
	logic [rhba_pkg::DV_W-1:0]     sr_w;
	logic [rhba_pkg::DV_W-1:0]     sg_w;
	logic [rhba_pkg::DV_W-1:0]     sb_w;
	logic [rhba_pkg::DV_W-1:0]     top_dv;
	logic                          ge_r;
	logic                          ge_g;
	logic                          ge_b;
	logic                          step_last;
	logic                          out_free;
	logic                          load_out;

	always_comb begin
		sr_w      = rhba_pkg::DV_W'(head.sum_red);
		sg_w      = rhba_pkg::DV_W'(head.sum_green);
		sb_w      = rhba_pkg::DV_W'(head.sum_blue);
		top_dv    = rhba_pkg::DV_W'(head.len) << rhba_pkg::PIX_W;
		ge_r      = (rem_r_q >= dv_q);
		ge_g      = (rem_g_q >= dv_q);
		ge_b      = (rem_b_q >= dv_q);
		step_last = (step_q == '0);
		out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rhba_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = rhba_pkg::BK_RUN;
				end
			end
			rhba_pkg::BK_RUN: begin
				if (step_last) begin
					state_d = rhba_pkg::BK_HOLD;
				end
			end
			rhba_pkg::BK_HOLD: begin
				if (out_free) begin
					state_d = rhba_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = rhba_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			rhba_pkg::BK_IDLE: begin
				q_pop = !q_empty;
			end
			rhba_pkg::BK_RUN: begin
			end
			rhba_pkg::BK_HOLD: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhba_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// restoring division, one quotient bit per cycle for all three channels
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_r_q <= sr_w;
			rem_g_q <= sg_w;
			rem_b_q <= sb_w;
			dv_q    <= top_dv >> 1;
			quo_r_q <= '0;
			quo_g_q <= '0;
			quo_b_q <= '0;
			sat_q   <= {sr_w >= top_dv, sg_w >= top_dv, sb_w >= top_dv};
			step_q  <= rhba_pkg::STEP_W'(rhba_pkg::PIX_W - 1);
		end else if (state_q == rhba_pkg::BK_RUN) begin
			if (ge_r) begin
				rem_r_q <= rem_r_q - dv_q;
			end
			if (ge_g) begin
				rem_g_q <= rem_g_q - dv_q;
			end
			if (ge_b) begin
				rem_b_q <= rem_b_q - dv_q;
			end
			quo_r_q <= {quo_r_q[rhba_pkg::PIX_W-2:0], ge_r};
			quo_g_q <= {quo_g_q[rhba_pkg::PIX_W-2:0], ge_g};
			quo_b_q <= {quo_b_q[rhba_pkg::PIX_W-2:0], ge_b};
			dv_q    <= dv_q >> 1;
			step_q  <= step_q - rhba_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_r_q <= quo_r_q | {rhba_pkg::PIX_W{sat_q[2]}};
			avg_g_q <= quo_g_q | {rhba_pkg::PIX_W{sat_q[1]}};
			avg_b_q <= quo_b_q | {rhba_pkg::PIX_W{sat_q[0]}};
		end
	end

	assign out_valid = out_valid_q;
	assign avg_red   = avg_r_q;
	assign avg_green = avg_g_q;
	assign avg_blue  = avg_b_q;

endmodule

// ----- design/rgb_horizontal_box_average_top.sv -----
`timescale 1ns / 1ps
// Top level of the RGB horizontal box average block.
// Depends on rhba_pkg, rhba_front, rhba_fifo and rhba_divider.

// Averages each run of group_length adjacent pixels into one RGB result,
// each channel truncated toward zero and capped at 255. Pixels are taken one
// per clock while the two-entry group queue has room; a completed group is
// then divided in the back end, which loads it, runs eight restoring-division
// steps and hands the result over to the output register before it takes the
// next group. Long groups sustain one pixel per clock while the output is not
// stalled; short groups are limited by the divider. A length of 0 acts as
// 1, larger than 4096 acts as 4096; a length change does not clear a partial
// group. Write cfg_data with cfg_we only while the block is idle.
module rgb_horizontal_box_average_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  rhba_pkg::cfg_t  cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  rhba_pkg::pix_t  red,
	input  rhba_pkg::pix_t  green,
	input  rhba_pkg::pix_t  blue,
	output logic            out_valid,
	input  logic            out_ready,
	output rhba_pkg::pix_t  avg_red,
	output rhba_pkg::pix_t  avg_green,
	output rhba_pkg::pix_t  avg_blue
);

	rhba_pkg::grp_t  push_data;
	rhba_pkg::grp_t  head;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	rhba_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	rhba_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	rhba_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (empty),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.avg_red   (avg_red),
		.avg_green (avg_green),
		.avg_blue  (avg_blue)
	);

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for rgb_horizontal_box_average_top: random RGB pixel streams
// under varying group lengths, checked against a group mean tracker. Depends on rhba_pkg.
module tb;

	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_ITEMS  = 1050;
	localparam int QUIET_AFTER   = 850;
	localparam int WIDE_ITEMS    = 240;

	typedef struct packed {
		rhba_pkg::pix_t red;
		rhba_pkg::pix_t green;
		rhba_pkg::pix_t blue;
	} rgb_t;

	class group_mean_tracker;
		rhba_pkg::cfg_t length_reg;
		rhba_pkg::sum_t acc_red;
		rhba_pkg::sum_t acc_green;
		rhba_pkg::sum_t acc_blue;
		logic [12:0]    pixel_count;
		rgb_t           pending_means[$];
		int             errors;

		function new();
			length_reg  = rhba_pkg::cfg_t'(1);
			acc_red     = '0;
			acc_green   = '0;
			acc_blue    = '0;
			pixel_count = '0;
			errors      = 0;
		endfunction

		function void set_length(rhba_pkg::cfg_t v);
			length_reg = v;
		endfunction

		function rhba_pkg::pix_t mean_of(rhba_pkg::sum_t s, logic [12:0] n);
			logic [19:0] q;
			q = s / n;
			return (q > 20'd255) ? 8'hFF : q[7:0];
		endfunction

		function void note_pixel(rhba_pkg::pix_t r, rhba_pkg::pix_t g, rhba_pkg::pix_t b);
			logic [12:0] eff;
			rgb_t        m;
			if (length_reg == '0) begin
				eff = 13'd1;
			end else if (length_reg > rhba_pkg::MAX_GROUP) begin
				eff = 13'(rhba_pkg::MAX_GROUP);
			end else begin
				eff = length_reg;
			end
			acc_red     += rhba_pkg::sum_t'(r);
			acc_green   += rhba_pkg::sum_t'(g);
			acc_blue    += rhba_pkg::sum_t'(b);
			pixel_count += 13'd1;
			if (pixel_count >= eff) begin
				m.red   = mean_of(acc_red, eff);
				m.green = mean_of(acc_green, eff);
				m.blue  = mean_of(acc_blue, eff);
				pending_means.push_back(m);
				acc_red     = '0;
				acc_green   = '0;
				acc_blue    = '0;
				pixel_count = '0;
			end
		endfunction

		function void check_mean(rhba_pkg::pix_t r, rhba_pkg::pix_t g, rhba_pkg::pix_t b);
			rgb_t m;
			if (pending_means.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d %0d %0d",
					$time, r, g, b);
				return;
			end
			m = pending_means.pop_front();
			if (m.red !== r) begin
				errors++;
				$display("%0t: avg_red expected %0d actual %0d", $time, m.red, r);
			end
			if (m.green !== g) begin
				errors++;
				$display("%0t: avg_green expected %0d actual %0d", $time, m.green, g);
			end
			if (m.blue !== b) begin
				errors++;
				$display("%0t: avg_blue expected %0d actual %0d", $time, m.blue, b);
			end
		endfunction

		function int pending();
			return pending_means.size();
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_we;
	rhba_pkg::cfg_t cfg_data;
	logic           in_valid;
	logic           in_ready;
	rhba_pkg::pix_t red;
	rhba_pkg::pix_t green;
	rhba_pkg::pix_t blue;
	logic           out_valid;
	logic           out_ready;
	rhba_pkg::pix_t avg_red;
	rhba_pkg::pix_t avg_green;
	rhba_pkg::pix_t avg_blue;

	group_mean_tracker tracker;
	bit idle_off      = 1'b0;
	int hold_requests = 0;
	int holds_done    = 0;

	rgb_horizontal_box_average_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.avg_red   (avg_red),
		.avg_green (avg_green),
		.avg_blue  (avg_blue)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && in_ready) begin
				tracker.note_pixel(red, green, blue);
			end
			if (out_valid && out_ready) begin
				tracker.check_mean(avg_red, avg_green, avg_blue);
			end
		end
	end

	function automatic rhba_pkg::pix_t rand_chan(input bit bright);
		if (bright && $urandom_range(0, 9) != 0) begin
			return 8'hFF;
		end
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return rhba_pkg::pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic rhba_pkg::cfg_t pick_length();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			return '0;
		end else if (sel <= 8) begin
			return rhba_pkg::cfg_t'($urandom_range(1, 4));
		end else if (sel <= 14) begin
			return rhba_pkg::cfg_t'($urandom_range(5, 16));
		end else if (sel <= 17) begin
			return rhba_pkg::cfg_t'($urandom_range(17, 64));
		end else if (sel == 18) begin
			return rhba_pkg::cfg_t'($urandom_range(65, 300));
		end
		return rhba_pkg::cfg_t'(1);
	endfunction

	task automatic send_pixel(input rhba_pkg::pix_t r, input rhba_pkg::pix_t g,
		input rhba_pkg::pix_t b);
		int gap;
		if (!idle_off && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drain the block, let partial groups settle, then write the length.
	task automatic change_length(input rhba_pkg::cfg_t v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		tracker.set_length(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : receiver
		int burst;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (holds_done < hold_requests) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (!idle_off && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 5);
				out_ready <= 1'b0;
				repeat (burst - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int             random_items;
		int             phase;
		int             n;
		int             eff;
		bit             bright;
		rhba_pkg::cfg_t len;
		tracker  = new();
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		red      <= '0;
		green    <= '0;
		blue     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of one
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hA5, 8'h5A, 8'h0F);
		// zero length acts as one
		change_length('0);
		send_pixel(8'h01, 8'h80, 8'hFE);
		send_pixel(8'h7F, 8'hFF, 8'h00);
		change_length(rhba_pkg::cfg_t'(3));
		repeat (3) send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'd10, 8'd0, 8'd255);
		send_pixel(8'd11, 8'd0, 8'd255);
		send_pixel(8'd13, 8'd1, 8'd254);
		// shrink mid-group so the quotient saturates
		change_length(rhba_pkg::cfg_t'(200));
		repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
		change_length(rhba_pkg::cfg_t'(2));
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		// grow mid-group
		change_length(rhba_pkg::cfg_t'(4));
		repeat (2) send_pixel(8'd100, 8'd50, 8'd3);
		change_length(rhba_pkg::cfg_t'(6));
		repeat (4) send_pixel(8'd7, 8'd200, 8'd31);

		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			bright = 1'b0;
			if (phase == 2) begin
				change_length(rhba_pkg::cfg_t'(1));
				hold_requests++;
				n = 80;
			end else if (phase == 4) begin
				// bright partial group at the largest length, finished by a later length
				change_length(rhba_pkg::cfg_t'(rhba_pkg::MAX_GROUP));
				n      = WIDE_ITEMS;
				bright = 1'b1;
			end else if (phase == 9) begin
				change_length(13'h1FFF);
				n = WIDE_ITEMS;
			end else begin
				len = pick_length();
				change_length(len);
				eff = (len == '0) ? 1 : int'(len);
				if (eff <= 16) begin
					n = eff * $urandom_range(1, 12);
				end else if (eff <= 64) begin
					n = eff * $urandom_range(1, 3);
				end else begin
					n = eff;
				end
				case ($urandom_range(0, 7))
					0: n += $urandom_range(1, eff);
					1: n = $urandom_range(1, eff);
					default: ;
				endcase
			end
			if (n > RANDOM_ITEMS - random_items) begin
				n = RANDOM_ITEMS - random_items;
			end
			idle_off = (random_items >= QUIET_AFTER) || ($urandom_range(0, 3) == 0);
			repeat (n) send_pixel(rand_chan(bright), rand_chan(bright), rand_chan(bright));
			random_items += n;
			phase++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb passed");
		end else begin
			if (tracker.pending() != 0) begin
				$display("%0t: %0d results never arrived", $time, tracker.pending());
			end
			$display("tb failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(10_000_000);
		$display("tb failed");
		$finish;
	end

endmodule
